[hdl/utf8_line_edit_buffer_core_defines.svh]
// Assertion macros for the UTF-8 line edit buffer.
// Included by the top level; no other dependencies.
`ifndef UTF8_LINE_EDIT_BUFFER_CORE_DEFINES_SVH
`define UTF8_LINE_EDIT_BUFFER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on the same clock edge.
`define ULEBUF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
// Antecedent on one edge, consequent on the next edge.
`define ULEBUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ULEBUF_ASSERT(lbl, clk, rstn, prop, msg)
`define ULEBUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hdl/ulebuf_pkg.sv]
// Shared types, constants and UTF-8 helper functions for the line edit buffer.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package ulebuf_pkg;

  localparam int OPCODE_W  = 2;
  localparam int DATA_W    = 8;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int LIMIT_W   = 9;
  localparam int LEN_OUT_W = 9;
  localparam int COUNT_W   = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [DATA_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [DATA_W-1:0] CONT_VAL   = 8'h80;
  localparam logic [DATA_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [DATA_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [DATA_W-1:0] LEAD2_VAL  = 8'hC0;
  localparam logic [DATA_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [DATA_W-1:0] LEAD3_VAL  = 8'hE0;
  localparam logic [DATA_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [DATA_W-1:0] LEAD4_VAL  = 8'hF0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_item;
    logic    write_byte;
    logic    rd_index;
    logic    rd_tail;
    logic    step_count;
    logic    commit_delete;
    logic    take_rbyte;
    logic    set_status;
    status_e status;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    idx_ok;
    logic    tail_cont;
    logic    look_last;
    logic    out_free;
  } sts_t;

  function automatic logic is_cont(input logic [DATA_W-1:0] b);
    return (b & CONT_MASK) == CONT_VAL;
  endfunction

  // Number of continuation bytes a lead byte announces.
  function automatic logic [1:0] expected_cont(input logic [DATA_W-1:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & ASCII_MASK) == '0) begin
      n = 2'd0;
    end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
      n = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
      n = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

[hdl/ulebuf_in_if.sv]
// Request channel of the line edit buffer: valid/ready plus the item fields.
// Depends on ulebuf_pkg for field widths.
`timescale 1ns / 1ps

interface ulebuf_in_if;
  logic                             valid;
  logic                             ready;
  logic [ulebuf_pkg::OPCODE_W-1:0]  opcode;
  logic [ulebuf_pkg::DATA_W-1:0]    data_byte;
  logic [ulebuf_pkg::INDEX_W-1:0]   read_index;

  modport source (output valid, opcode, data_byte, read_index, input ready);
  modport sink   (input valid, opcode, data_byte, read_index, output ready);
endinterface

[hdl/ulebuf_out_if.sv]
// Response channel of the line edit buffer: valid/ready plus the result fields.
// Depends on ulebuf_pkg for field widths.
`timescale 1ns / 1ps

interface ulebuf_out_if;
  logic                              valid;
  logic                              ready;
  logic [ulebuf_pkg::STATUS_W-1:0]   status;
  logic [ulebuf_pkg::LEN_OUT_W-1:0]  length_after;
  logic [ulebuf_pkg::COUNT_W-1:0]    removed_count;
  logic [ulebuf_pkg::DATA_W-1:0]     read_byte;

  modport source (output valid, status, length_after, removed_count, read_byte,
                  input ready);
  modport sink   (input valid, status, length_after, removed_count, read_byte,
                  output ready);
endinterface

[hdl/ulebuf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ulebuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ulebuf_ctrl.sv]
// Controller state machine of the line edit buffer.
// Depends on ulebuf_pkg for the command and status structs.
`timescale 1ns / 1ps

module ulebuf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ulebuf_pkg::sts_t  sts_i,
  output ulebuf_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_LOOK     = 5'b00100,
    S_RD_WAIT  = 5'b01000,
    S_FINISH   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  ulebuf_pkg::cmd_t cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.latch_item = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.set_status = 1'b1;
        cmd.status     = ulebuf_pkg::ST_DONE;
        state_d        = S_FINISH;
        case (sts_i.op)
          ulebuf_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              cmd.status = ulebuf_pkg::ST_FULL;
            end else begin
              cmd.write_byte = 1'b1;
            end
          end
          ulebuf_pkg::OP_DELETE: begin
            if (sts_i.empty) begin
              cmd.status = ulebuf_pkg::ST_EMPTY;
            end else begin
              cmd.rd_tail = 1'b1;
              state_d     = S_LOOK;
            end
          end
          ulebuf_pkg::OP_READ: begin
            if (sts_i.idx_ok) begin
              cmd.rd_index = 1'b1;
              state_d      = S_RD_WAIT;
            end else begin
              cmd.status = ulebuf_pkg::ST_RANGE;
            end
          end
          default: begin
            cmd.status = ulebuf_pkg::ST_DONE;
          end
        endcase
      end
      S_LOOK: begin
        // Walk back over continuation bytes, up to four or the text start.
        if (sts_i.tail_cont && !sts_i.look_last) begin
          cmd.rd_tail    = 1'b1;
          cmd.step_count = 1'b1;
        end else begin
          cmd.commit_delete = 1'b1;
          state_d           = S_FINISH;
        end
      end
      S_RD_WAIT: begin
        cmd.take_rbyte = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

[hdl/ulebuf_dp.sv]
// Datapath of the line edit buffer: text store, length, limit, look-back
// counter and output register. Depends on ulebuf_pkg and ulebuf_ram.
`timescale 1ns / 1ps

module ulebuf_dp #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ulebuf_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  logic [ulebuf_pkg::OPCODE_W-1:0]    in_opcode_i,
  input  logic [ulebuf_pkg::DATA_W-1:0]      in_data_byte_i,
  input  logic [ulebuf_pkg::INDEX_W-1:0]     in_read_index_i,
  input  ulebuf_pkg::cmd_t                   cmd_i,
  output ulebuf_pkg::sts_t                   sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [ulebuf_pkg::STATUS_W-1:0]    out_status_o,
  output logic [ulebuf_pkg::LEN_OUT_W-1:0]   out_length_after_o,
  output logic [ulebuf_pkg::COUNT_W-1:0]     out_removed_count_o,
  output logic [ulebuf_pkg::DATA_W-1:0]      out_read_byte_o
);

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
  localparam int CMP_W  = (LEN_W > ulebuf_pkg::LIMIT_W) ? LEN_W : ulebuf_pkg::LIMIT_W;
  localparam logic [CMP_W-1:0] CAP = CMP_W'(BUFFER_BYTES);

  logic [ulebuf_pkg::LIMIT_W-1:0]   limit_q;
  logic [LEN_W-1:0]                 len_q, len_d;
  logic [1:0]                       cnt_q, cnt_d;
  ulebuf_pkg::opcode_e              op_q;
  logic [ulebuf_pkg::DATA_W-1:0]    data_q;
  logic [ulebuf_pkg::INDEX_W-1:0]   idx_q;
  ulebuf_pkg::status_e              status_q;
  logic [ulebuf_pkg::COUNT_W-1:0]   removed_q;
  logic [ulebuf_pkg::DATA_W-1:0]    rbyte_q;

  logic                              out_valid_q;
  logic [ulebuf_pkg::STATUS_W-1:0]   out_status_q;
  logic [ulebuf_pkg::LEN_OUT_W-1:0]  out_len_q;
  logic [ulebuf_pkg::COUNT_W-1:0]    out_removed_q;
  logic [ulebuf_pkg::DATA_W-1:0]     out_rbyte_q;

  logic [CMP_W-1:0]                 limit_ext, limit_eff, len_ext, idx_ext;
  logic [LEN_W-1:0]                 tail_pos;
  logic [ADDR_W-1:0]                rd_addr;
  logic [ulebuf_pkg::DATA_W-1:0]    rd_data;
  logic [ulebuf_pkg::COUNT_W-1:0]   cnt_next, span;
  logic                             tail_cont;

  assign limit_ext = CMP_W'(limit_q);
  assign limit_eff = (limit_ext > CAP) ? CAP : limit_ext;
  assign len_ext   = CMP_W'(len_q);
  assign idx_ext   = CMP_W'(idx_q);

  assign cnt_d = cmd_i.latch_item ? 2'd0 :
                 cmd_i.step_count ? (cnt_q + 2'd1) : cnt_q;

  // Tail reads start at the last byte, then one before the last one examined.
  assign tail_pos = len_q - LEN_W'(1) - LEN_W'(cnt_d);
  assign rd_addr  = cmd_i.rd_index ? idx_ext[ADDR_W-1:0] : tail_pos[ADDR_W-1:0];

  assign cnt_next  = {1'b0, cnt_q} + 3'd1;
  assign tail_cont = ulebuf_pkg::is_cont(rd_data);
  assign span      = (!tail_cont && (ulebuf_pkg::expected_cont(rd_data) == cnt_q)) ?
                     cnt_next : 3'd1;

  always_comb begin
    len_d = len_q;
    if (cmd_i.write_byte) begin
      len_d = len_q + LEN_W'(1);
    end else if (cmd_i.commit_delete) begin
      len_d = len_q - LEN_W'(span);
    end
  end

  ulebuf_ram #(
    .WIDTH (ulebuf_pkg::DATA_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_byte),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (data_q),
    .re_i    (cmd_i.rd_index | cmd_i.rd_tail),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= ulebuf_pkg::LIMIT_RESET;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      len_q <= len_d;
      cnt_q <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q      <= ulebuf_pkg::opcode_e'(in_opcode_i);
      data_q    <= in_data_byte_i;
      idx_q     <= in_read_index_i;
      removed_q <= '0;
      rbyte_q   <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.commit_delete) begin
      removed_q <= span;
    end
    if (cmd_i.take_rbyte) begin
      rbyte_q <= rd_data;
    end
    if (cmd_i.load_out) begin
      out_status_q  <= status_q;
      out_len_q     <= len_ext[ulebuf_pkg::LEN_OUT_W-1:0];
      out_removed_q <= removed_q;
      out_rbyte_q   <= rbyte_q;
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.full      = len_ext >= limit_eff;
    sts_o.empty     = (len_q == '0);
    sts_o.idx_ok    = idx_ext < len_ext;
    sts_o.tail_cont = tail_cont;
    sts_o.look_last = (cnt_next == 3'd4) || (CMP_W'(cnt_next) == len_ext);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_length_after_o  = out_len_q;
  assign out_removed_count_o = out_removed_q;
  assign out_read_byte_o     = out_rbyte_q;

endmodule

[hdl/utf8_line_edit_buffer_core.sv]
// The buffer works on one transaction at a time and accepts the next request
// only after the result has been loaded into the output register. A delete
// examines the tail of the text one byte at a time, at most four bytes; the
// single read port of the text store yields one byte per cycle in the look-back.
// Reset (rst_ni, asynchronous, active low) empties the text and sets the byte
// limit to 256; store contents stay undefined and need no clearing pass.
`timescale 1ns / 1ps
`include "utf8_line_edit_buffer_core_defines.svh"

// Top level of the UTF-8 aware line edit buffer. Depends on ulebuf_pkg,
// the channel interfaces, ulebuf_ctrl, ulebuf_dp and ulebuf_ram.
module utf8_line_edit_buffer_core #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ulebuf_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  ulebuf_in_if.sink                       req_i,
  ulebuf_out_if.source                    rsp_o
);

  // The controller and the datapath talk only through these two structs.
  ulebuf_pkg::cmd_t cmd;
  ulebuf_pkg::sts_t sts;

  // The controller sequences each transaction: it latches the request, decodes
  // it, walks the tail of the text for a delete and finally hands the result
  // to the output register. It only accepts a new request from its idle state.
  ulebuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the text store, the length and limit registers, the
  // look-back counter and the output register, so a finished result can wait
  // for the consumer while the next request is already accepted and decoded.
  ulebuf_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_opcode_i         (req_i.opcode),
    .in_data_byte_i      (req_i.data_byte),
    .in_read_index_i     (req_i.read_index),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .out_status_o        (rsp_o.status),
    .out_length_after_o  (rsp_o.length_after),
    .out_removed_count_o (rsp_o.removed_count),
    .out_read_byte_o     (rsp_o.read_byte)
  );

  // A store write must never happen while the buffer is at its limit.
  `ULEBUF_ASSERT(a_no_write_when_full, clk_i, rst_ni, cmd.write_byte |-> !sts.full, "write while full")

  // Only one transaction is in work at a time: after an accept, ready drops.
  `ULEBUF_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "accept while busy")

  // A delete removes one to four bytes and only a successful one reports them.
  `ULEBUF_ASSERT(a_removed_bound, clk_i, rst_ni, rsp_o.valid |-> rsp_o.removed_count <= 3'd4, "removed count above four")
  `ULEBUF_ASSERT(a_removed_done, clk_i, rst_ni, rsp_o.valid && (rsp_o.removed_count != 3'd0) |-> rsp_o.status == ulebuf_pkg::ST_DONE, "removed bytes on failed item")

endmodule

[tb/testbench.sv]
// Self-checking testbench for utf8_line_edit_buffer_core: directed rows, then random
// editing traffic in several byte-limit settings. It needs ulebuf_pkg, the two
// channel interfaces and the RTL of the buffer; it reads no files.
`timescale 1ns / 1ps

module testbench;

  localparam int TEXT_BYTES   = 256;   // capacity of the text store in the DUT
  localparam int GAP_PCT      = 37;    // chance of an idle cycle on either side
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 12;    // worst-case latency plus some margin
  localparam int STALL_LIMIT  = 3000;  // cycles without any transaction

  // One result transaction of the buffer.
  typedef struct packed {
    ulebuf_pkg::status_e status;
    logic [8:0]          length_after;
    logic [2:0]          removed_count;
    logic [7:0]          read_byte;
  } edit_result_t;

  // One directed row; when known is set, the result is written out by hand.
  typedef struct packed {
    ulebuf_pkg::opcode_e op;
    logic [7:0]          data_byte;
    logic [7:0]          read_index;
    logic                known;
    edit_result_t        result;
  } edit_row_t;

  localparam edit_result_t UNTYPED = '{ulebuf_pkg::ST_DONE, 9'd0, 3'd0, 8'h00};
  localparam int N_ROWS = 24;

  // Directed editing session from reset (limit 256). Rows without a typed
  // result are checked against the predictor.
  localparam edit_row_t EDIT_ROWS [N_ROWS] = '{
    // Empty text: read out of range, delete with nothing to remove, no-op.
    '{ulebuf_pkg::OP_READ,   8'h00, 8'h00, 1'b1, '{ulebuf_pkg::ST_RANGE, 9'd0, 3'd0, 8'h00}},
    '{ulebuf_pkg::OP_DELETE, 8'h00, 8'h00, 1'b1, '{ulebuf_pkg::ST_EMPTY, 9'd0, 3'd0, 8'h00}},
    '{ulebuf_pkg::OP_NOP,    8'hFF, 8'hFF, 1'b1, '{ulebuf_pkg::ST_DONE,  9'd0, 3'd0, 8'h00}},
    // A lone continuation byte at the very start of the text.
    '{ulebuf_pkg::OP_INSERT, 8'h80, 8'h00, 1'b1, '{ulebuf_pkg::ST_DONE,  9'd1, 3'd0, 8'h00}},
    '{ulebuf_pkg::OP_DELETE, 8'h00, 8'h00, 1'b0, UNTYPED},
    // Byte extremes and read-back, including the read past the end.
    '{ulebuf_pkg::OP_INSERT, 8'h00, 8'h00, 1'b1, '{ulebuf_pkg::ST_DONE,  9'd1, 3'd0, 8'h00}},
    '{ulebuf_pkg::OP_INSERT, 8'h41, 8'h00, 1'b1, '{ulebuf_pkg::ST_DONE,  9'd2, 3'd0, 8'h00}},
    '{ulebuf_pkg::OP_READ,   8'h00, 8'h00, 1'b1, '{ulebuf_pkg::ST_DONE,  9'd2, 3'd0, 8'h00}},
    '{ulebuf_pkg::OP_READ,   8'h00, 8'h01, 1'b1, '{ulebuf_pkg::ST_DONE,  9'd2, 3'd0, 8'h41}},
    '{ulebuf_pkg::OP_READ,   8'h00, 8'hFF, 1'b1, '{ulebuf_pkg::ST_RANGE, 9'd2, 3'd0, 8'h00}},
    // Two-byte character removed whole.
    '{ulebuf_pkg::OP_INSERT, 8'hC3, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'hA9, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_DELETE, 8'h00, 8'h00, 1'b0, UNTYPED},
    // Four-byte character removed whole.
    '{ulebuf_pkg::OP_INSERT, 8'hF0, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'h9F, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'h98, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'h80, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_DELETE, 8'h00, 8'h00, 1'b0, UNTYPED},
    // Four continuation bytes at the tail, then three behind an ASCII byte.
    '{ulebuf_pkg::OP_INSERT, 8'h80, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'hBF, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'h80, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_INSERT, 8'hBF, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_DELETE, 8'h00, 8'h00, 1'b0, UNTYPED},
    '{ulebuf_pkg::OP_DELETE, 8'h00, 8'h00, 1'b0, UNTYPED}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ulebuf_pkg::LIMIT_W-1:0] cfg_wdata_i;

  ulebuf_in_if  req_if ();
  ulebuf_out_if rsp_if ();

  utf8_line_edit_buffer_core #(
    .BUFFER_BYTES (TEXT_BYTES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Predictor state: a private copy of the text and of the byte limit.
  logic [7:0]   text_mem [TEXT_BYTES];
  int           text_len;
  logic [8:0]   byte_limit;

  // Results the buffer still owes, oldest first.
  edit_result_t pending_results [$];

  int  error_count;
  int  edits_sent;
  int  results_seen;
  int  rejected_inserts;
  int  empty_deletes;
  int  range_reads;
  int  delete_spans [5];

  bit  gaps_on;        // random idling on both channels
  bit  hold_request;   // asks the receiver for one long hold-off
  int  hold_left;

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Continuation bytes announced by a lead byte; zero for anything else.
  function automatic int lead_continuations(input logic [7:0] lead);
    int n;
    n = 0;
    if (lead[7] == 1'b0) begin
      n = 0;
    end else if (lead[7:5] == 3'b110) begin
      n = 1;
    end else if (lead[7:4] == 4'b1110) begin
      n = 2;
    end else if (lead[7:3] == 5'b11110) begin
      n = 3;
    end
    return n;
  endfunction

  // Bytes a delete takes off a non-empty text. The look-back stops after four
  // bytes; a run of four or more continuations, one that reaches the start
  // of the text, or one that does not match its lead byte loses a single byte.
  function automatic int tail_char_bytes();
    int tail;
    tail = 0;
    while (tail < 4 && tail < text_len && text_mem[text_len - 1 - tail][7:6] == 2'b10) begin
      tail++;
    end
    if (tail == 0 || tail >= 4 || tail >= text_len) begin
      return 1;
    end
    return (lead_continuations(text_mem[text_len - 1 - tail]) == tail) ? tail + 1 : 1;
  endfunction

  // Applies one edit to the predictor state and returns the result it owes.
  function automatic edit_result_t apply_edit(input ulebuf_pkg::opcode_e op,
                                              input logic [7:0] data_byte,
                                              input logic [7:0] read_index);
    edit_result_t res;
    int           cap;
    int           span;
    res = UNTYPED;
    // A limit above the capacity acts as the capacity.
    cap = (byte_limit > TEXT_BYTES) ? TEXT_BYTES : int'(byte_limit);
    case (op)
      ulebuf_pkg::OP_INSERT: begin
        if (text_len >= cap) begin
          res.status = ulebuf_pkg::ST_FULL;
          rejected_inserts++;
        end else begin
          text_mem[text_len] = data_byte;
          text_len++;
        end
      end
      ulebuf_pkg::OP_DELETE: begin
        if (text_len == 0) begin
          res.status = ulebuf_pkg::ST_EMPTY;
          empty_deletes++;
        end else begin
          span = tail_char_bytes();
          text_len -= span;
          res.removed_count = span[2:0];
          delete_spans[span]++;
        end
      end
      ulebuf_pkg::OP_READ: begin
        if (int'(read_index) < text_len) begin
          res.read_byte = text_mem[read_index];
        end else begin
          res.status = ulebuf_pkg::ST_RANGE;
          range_reads++;
        end
      end
      default: begin
        // The no-op changes nothing.
      end
    endcase
    res.length_after = text_len[8:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // Offers one edit on the request channel, with random idle cycles ahead of
  // it, and waits for the transaction. The expectation is recorded at the
  // edge where the buffer accepts it, so the predictor follows the exact
  // order of acceptance. A typed result, where given, replaces the prediction.
  task automatic offer_edit(input ulebuf_pkg::opcode_e op, input logic [7:0] data_byte,
                            input logic [7:0] read_index, input bit known,
                            input edit_result_t typed);
    edit_result_t predicted;
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.data_byte  <= data_byte;
    req_if.read_index <= read_index;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    predicted = apply_edit(op, data_byte, read_index);
    if (known) begin
      predicted = typed;
    end
    pending_results.insert(pending_results.size(), predicted);
    edits_sent++;
  endtask

  // Waits until every owed result has come back and the buffer has settled.
  task automatic drain_results();
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Byte-limit writes happen only with the buffer idle; the request channel
  // is quiet at that point.
  task automatic set_byte_limit(input logic [8:0] value);
    req_if.valid <= 1'b0;
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    byte_limit = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random editing traffic. Most inserts are whole UTF-8 characters with
  // random content; one in ten is a raw byte and one in ten a character cut
  // short if it is multi-byte, so broken tails also reach the delete logic.
  task automatic edit_session(input int n_edits, input int insert_pct);
    int         sent;
    int         pick;
    int         kind;
    int         n_bytes;
    int         n_cont;
    logic [7:0] lead;
    logic [7:0] index;
    sent = 0;
    while (sent < n_edits) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          offer_edit(ulebuf_pkg::OP_INSERT, 8'($urandom_range(0, 255)), 8'($urandom), 1'b0,
                     UNTYPED);
          sent++;
        end else begin
          n_bytes = $urandom_range(1, 4);
          case (n_bytes)
            1:       lead = 8'($urandom_range(8'h00, 8'h7F));
            2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
          endcase
          n_cont = n_bytes - 1;
          if (kind == 1 && n_bytes > 1) begin
            n_cont = $urandom_range(0, n_bytes - 2);
          end
          offer_edit(ulebuf_pkg::OP_INSERT, lead, 8'($urandom), 1'b0, UNTYPED);
          sent++;
          for (int k = 0; k < n_cont; k++) begin
            offer_edit(ulebuf_pkg::OP_INSERT, 8'($urandom_range(8'h80, 8'hBF)), 8'($urandom),
                       1'b0, UNTYPED);
            sent++;
          end
        end
      end else if (pick < insert_pct + (100 - insert_pct) * 55 / 100) begin
        offer_edit(ulebuf_pkg::OP_DELETE, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        sent++;
      end else if (pick < 98) begin
        // Mostly indexes inside the text, sometimes anywhere.
        if (text_len > 0 && $urandom_range(0, 4) != 0) begin
          index = 8'($urandom_range(0, (text_len > 256 ? 256 : text_len) - 1));
        end else begin
          index = 8'($urandom_range(0, 255));
        end
        offer_edit(ulebuf_pkg::OP_READ, 8'($urandom), index, 1'b0, UNTYPED);
        sent++;
      end else begin
        offer_edit(ulebuf_pkg::OP_NOP, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        sent++;
      end
    end
  endtask

  // Response side: checks every accepted result against the oldest
  // expectation, then decides the ready level for the next cycle. A hold-off
  // request keeps ready low for a long stretch while the sender keeps
  // offering, so the buffer backs up and stalls its input.
  initial begin
    edit_result_t want;
    rsp_if.ready = 1'b0;
    hold_left    = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("results pending", 0, 1);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.status !== want.status) begin
            report_mismatch("status", int'(rsp_if.status), int'(want.status));
          end
          if (rsp_if.length_after !== want.length_after) begin
            report_mismatch("length_after", int'(rsp_if.length_after),
                            int'(want.length_after));
          end
          if (rsp_if.removed_count !== want.removed_count) begin
            report_mismatch("removed_count", int'(rsp_if.removed_count),
                            int'(want.removed_count));
          end
          if (rsp_if.read_byte !== want.read_byte) begin
            report_mismatch("read_byte", int'(rsp_if.read_byte), int'(want.read_byte));
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for
  // far longer than the slowest correct run could take.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("[%0t] Watchdog: no transaction for %0d cycles, %0d results pending",
                 $time, quiet, pending_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    // Every input is known from time zero; reset is held low before the first edit.
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.opcode     = ulebuf_pkg::OP_NOP;
    req_if.data_byte  = '0;
    req_if.read_index = '0;
    error_count       = 0;
    edits_sent        = 0;
    results_seen      = 0;
    rejected_inserts  = 0;
    empty_deletes     = 0;
    range_reads       = 0;
    delete_spans      = '{default: 0};
    gaps_on           = 1'b1;
    hold_request      = 1'b0;
    text_len          = 0;
    byte_limit        = ulebuf_pkg::LIMIT_RESET;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      text_mem[i] = 8'h00;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed session at the reset limit.
    for (int r = 0; r < N_ROWS; r++) begin
      offer_edit(EDIT_ROWS[r].op, EDIT_ROWS[r].data_byte, EDIT_ROWS[r].read_index,
                 EDIT_ROWS[r].known, EDIT_ROWS[r].result);
    end

    // Limit above the capacity: the text fills to the store size, and inserts
    // past it are rejected. A long receiver hold-off starts this session.
    set_byte_limit(9'd511);
    hold_request = 1'b1;
    edit_session(450, 85);

    // Limit under the held length: the text stays, inserts are refused until
    // deletes bring it below the limit.
    set_byte_limit(9'd100);
    edit_session(250, 25);

    // Zero limit: every insert is refused.
    set_byte_limit(9'd0);
    edit_session(100, 50);

    // Reset value again, this time without any idling on either side.
    set_byte_limit(9'd256);
    gaps_on = 1'b0;
    edit_session(300, 60);
    gaps_on = 1'b1;

    // Tiny limits and one random limit, with another hold-off.
    set_byte_limit(9'd3);
    edit_session(150, 50);
    set_byte_limit(9'($urandom_range(1, 511)));
    hold_request = 1'b1;
    edit_session(350, 55);
    set_byte_limit(9'd1);
    edit_session(100, 50);

    // Drain and give any stray result time to show up.
    req_if.valid <= 1'b0;
    drain_results();

    $display("Sent %0d edits, checked %0d results; %0d inserts refused, %0d empty deletes,",
             edits_sent, results_seen, rejected_inserts, empty_deletes);
    $display("%0d reads out of range; deletes removing 1/2/3/4 bytes: %0d/%0d/%0d/%0d",
             range_reads, delete_spans[1], delete_spans[2], delete_spans[3],
             delete_spans[4]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ulebuf_pkg.sv
hdl/ulebuf_in_if.sv
hdl/ulebuf_out_if.sv
hdl/ulebuf_ram.sv
hdl/ulebuf_ctrl.sv
hdl/ulebuf_dp.sv
hdl/utf8_line_edit_buffer_core.sv
tb/testbench.sv
